[src/u8rx_pkg.sv]
`timescale 1ns / 1ps

package u8rx_pkg;

    // Field widths
    localparam int PERIOD_W  = 16;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_ENABLE  = 2'd1;

    // Byte handed from the receiver to the FIFO
    typedef struct packed {
        logic              push;
        logic [BYTE_W-1:0] data;
    } t_rx_push;

endpackage

[src/u8rx_ram.sv]
`timescale 1ns / 1ps

module u8rx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read (old data on a collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/u8rx_tx.sv]
`timescale 1ns / 1ps

module u8rx_tx import u8rx_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [PERIOD_W-1:0] i_bit_period,
    input  logic                i_send,
    input  logic [BYTE_W-1:0]   i_send_byte,
    output logic                o_tx_line,
    output logic                o_busy
);

    // Bit counter: 0 idle, 1 start, 2..9 data, 10 stop, 11 end of frame
    localparam logic [3:0] TX_IDLE       = 4'd0;
    localparam logic [3:0] TX_START      = 4'd1;
    localparam logic [3:0] TX_FIRST_DATA = 4'd2;
    localparam logic [3:0] TX_LAST_DATA  = 4'd9;
    localparam logic [3:0] TX_STOP       = 4'd10;

    logic [3:0]          r_cnt,   n_cnt;
    logic [PERIOD_W-1:0] r_timer, n_timer;
    logic [BYTE_W-1:0]   r_shift, n_shift;
    logic                r_level, n_level;

    // One tick of the transmitter, then a new frame if it was idle; a zero bit period holds it idle
    always_comb begin
        n_cnt   = r_cnt;
        n_timer = r_timer;
        n_shift = r_shift;
        n_level = r_level;
        if (i_bit_period == '0) begin
            n_cnt   = TX_IDLE;
            n_timer = '0;
            n_level = 1'b1;
        end else begin
            if (r_cnt != TX_IDLE) begin
                if (r_timer > PERIOD_W'(1)) begin
                    n_timer = r_timer - 1'b1;
                end else begin
                    n_timer = i_bit_period;
                    n_cnt   = r_cnt + 1'b1;
                    priority if (n_cnt >= TX_FIRST_DATA && n_cnt <= TX_LAST_DATA) begin
                        n_level = r_shift[0];
                        n_shift = {1'b0, r_shift[BYTE_W-1:1]};
                    end else if (n_cnt == TX_STOP) begin
                        n_level = 1'b1;
                    end else begin
                        n_cnt   = TX_IDLE;
                        n_level = 1'b1;
                        n_timer = '0;
                    end
                end
            end
            if (r_cnt == TX_IDLE && i_send) begin
                n_shift = i_send_byte;
                n_level = 1'b0;
                n_cnt   = TX_START;
                n_timer = i_bit_period;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= TX_IDLE;
            r_timer <= '0;
            r_shift <= '0;
            r_level <= 1'b1;
        end else if (i_en) begin
            r_cnt   <= n_cnt;
            r_timer <= n_timer;
            r_shift <= n_shift;
            r_level <= n_level;
        end
    end

    assign o_tx_line = r_level;
    assign o_busy    = (r_cnt != TX_IDLE);

    // End of frame is never left standing in the counter
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= TX_STOP)
        else $error("tx bit counter beyond stop bit");

    // While busy the line only moves on a bit boundary
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_cnt != TX_IDLE && r_timer > PERIOD_W'(1) && i_bit_period != '0)
        |=> $stable(r_level))
        else $error("tx line changed inside a bit period");

endmodule

[src/u8rx_rx.sv]
`timescale 1ns / 1ps

module u8rx_rx import u8rx_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [PERIOD_W-1:0] i_bit_period,
    input  logic                i_rx_enable,
    input  logic                i_rx_line,
    output t_rx_push            o_push
);

    typedef enum logic [3:0] {
        RX_IDLE   = 4'b0001,
        RX_CENTER = 4'b0010,
        RX_DATA   = 4'b0100,
        RX_STOP   = 4'b1000
    } t_rx_phase;

    t_rx_phase           r_phase, n_phase;
    logic [PERIOD_W-1:0] r_timer, n_timer;
    logic [3:0]          r_cnt,   n_cnt;
    logic [BYTE_W-1:0]   r_shift, n_shift;
    logic                r_prev;
    logic                w_push;
    logic [PERIOD_W+1:0] w_three;

    // Three quarters of a bit period for the stop wait
    assign w_three = {2'b00, i_bit_period} + {1'b0, i_bit_period, 1'b0};

    // Receiver step
    always_comb begin
        n_phase = r_phase;
        n_timer = r_timer;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        w_push  = 1'b0;
        if (i_bit_period == '0) begin
            n_phase = RX_IDLE;
            n_timer = '0;
            n_cnt   = '0;
        end else if (r_phase == RX_IDLE) begin
            if (i_rx_enable && r_prev && !i_rx_line) begin
                n_phase = RX_CENTER;
                n_timer = {1'b0, i_bit_period[PERIOD_W-1:1]};
                n_cnt   = '0;
            end
        end else if (r_timer > PERIOD_W'(1)) begin
            n_timer = r_timer - 1'b1;
        end else begin
            unique case (r_phase)
                RX_CENTER: begin
                    n_phase = RX_DATA;
                    n_timer = i_bit_period;
                    n_cnt   = '0;
                end
                RX_DATA: begin
                    n_shift = {i_rx_line, r_shift[BYTE_W-1:1]};
                    n_cnt   = r_cnt + 1'b1;
                    if (n_cnt >= 4'(BYTE_W)) begin
                        w_push  = 1'b1;
                        n_phase = RX_STOP;
                        n_timer = w_three[PERIOD_W+1:2];
                        n_cnt   = '0;
                    end else begin
                        n_timer = i_bit_period;
                    end
                end
                RX_STOP: begin
                    n_phase = RX_IDLE;
                    n_timer = '0;
                end
                default: begin
                    n_phase = RX_IDLE;
                    n_timer = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= RX_IDLE;
            r_timer <= '0;
            r_cnt   <= '0;
            r_shift <= '0;
            r_prev  <= 1'b1;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_prev  <= i_rx_line;
        end
    end

    assign o_push.push = i_en && w_push;
    assign o_push.data = n_shift;

    // Data bit counter stays below a full byte between items
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt < 4'(BYTE_W))
        else $error("rx bit counter overran a byte");

    // Bits are only counted while sampling data
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != RX_DATA) |-> (r_cnt == '0))
        else $error("rx bit counter live outside data phase");

endmodule

[src/u8rx_fifo.sv]
`timescale 1ns / 1ps

module u8rx_fifo import u8rx_pkg::*; #(
    parameter int FIFO_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_pop,
    input  logic                          i_clear,
    input  t_rx_push                      i_push,
    output logic [BYTE_W-1:0]             o_head_byte,
    output logic                          o_empty,
    output logic [$clog2(FIFO_DEPTH)-1:0] o_count,
    output logic                          o_overflow
);

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam logic [PW-1:0] LAST = PW'(FIFO_DEPTH - 1);

    logic [PW-1:0]     r_head, n_head;
    logic [PW-1:0]     r_tail, n_tail;
    logic [PW-1:0]     r_count, n_count;
    logic              r_ovf, n_ovf;
    logic              r_bypass;
    logic [BYTE_W-1:0] r_bypass_data;
    logic [PW-1:0]     w_tail0, w_count0;
    logic              w_we;
    logic [BYTE_W-1:0] w_rdata;

    // Clear or pop first, then the received byte is stored if there is room
    always_comb begin
        n_head   = r_head;
        w_tail0  = r_tail;
        w_count0 = r_count;
        n_ovf    = r_ovf;
        if (i_clear) begin
            n_head   = '0;
            w_tail0  = '0;
            w_count0 = '0;
            n_ovf    = 1'b0;
        end else if (i_pop && r_count != '0) begin
            n_head   = (r_head == LAST) ? '0 : r_head + 1'b1;
            w_count0 = r_count - 1'b1;
        end
        w_we    = i_push.push && (w_count0 != LAST);
        n_tail  = w_tail0;
        n_count = w_count0;
        if (w_we) begin
            n_tail  = (w_tail0 == LAST) ? '0 : w_tail0 + 1'b1;
            n_count = w_count0 + 1'b1;
        end else if (i_push.push) begin
            n_ovf = 1'b1;
        end
    end

    u8rx_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_tail0),
        .i_wdata (i_push.data),
        .i_re    (i_en),
        .i_raddr (n_head),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_bypass <= 1'b0;
        end else if (i_en) begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_bypass <= w_we && (w_tail0 == n_head);
        end
    end

    // Byte written into the slot being read this item
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bypass_data <= i_push.data;
        end
    end

    assign o_empty     = (r_count == '0);
    assign o_count     = r_count;
    assign o_overflow  = r_ovf;
    assign o_head_byte = o_empty ? '0 : (r_bypass ? r_bypass_data : w_rdata);

    // One slot always stays free
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_count <= LAST)
        else $error("fifo fill beyond capacity");

    // Fill count agrees with the pointers
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == (r_head == r_tail))
        else $error("fifo count and pointers disagree");

endmodule

[src/uart_8n1_with_rx_ring_buffer.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    rx_line, pop/clear/send strobes, send_byte
// out       output     o_out_valid / i_out_ready  tx_line, head_byte, fifo_empty/count,
//                                                  overflow, tx_busy
// cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// Each item is one tick of the serial logic: one item per cycle while results are
// taken, with its result registered in the same cycle the item is taken.
// The transmitter, receiver and FIFO state registers double as the result register;
// head_byte comes from the FIFO RAM's registered read port.
// A stalled result blocks the next item only while it is not being taken.
// Synchronous active-low reset; no clearing pass is needed after reset.

module uart_8n1_with_rx_ring_buffer import u8rx_pkg::*; #(
    parameter int FIFO_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_rx_line,
    input  logic                          i_pop_strobe,
    input  logic                          i_clear_strobe,
    input  logic                          i_send_strobe,
    input  logic [BYTE_W-1:0]             i_send_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_tx_line,
    output logic [BYTE_W-1:0]             o_head_byte,
    output logic                          o_fifo_empty,
    output logic [$clog2(FIFO_DEPTH)-1:0] o_fifo_count,
    output logic                          o_overflow,
    output logic                          o_tx_busy,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [PERIOD_W-1:0]           i_cfg_data
);

    logic [PERIOD_W-1:0] r_bit_period;
    logic                r_rx_enable;
    logic                r_out_valid;
    logic                w_accept;
    t_rx_push            w_push;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= '0;
            r_rx_enable  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BIT_PERIOD: r_bit_period <= i_cfg_data;
                CFG_RX_ENABLE:  r_rx_enable  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Handshake: take an item whenever the result slot is free or being taken
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    u8rx_tx u_tx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_accept),
        .i_bit_period (r_bit_period),
        .i_send       (i_send_strobe),
        .i_send_byte  (i_send_byte),
        .o_tx_line    (o_tx_line),
        .o_busy       (o_tx_busy)
    );

    u8rx_rx u_rx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_accept),
        .i_bit_period (r_bit_period),
        .i_rx_enable  (r_rx_enable),
        .i_rx_line    (i_rx_line),
        .o_push       (w_push)
    );

    u8rx_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_accept),
        .i_pop       (i_pop_strobe),
        .i_clear     (i_clear_strobe),
        .i_push      (w_push),
        .o_head_byte (o_head_byte),
        .o_empty     (o_fifo_empty),
        .o_count     (o_fifo_count),
        .o_overflow  (o_overflow)
    );

    // Every accepted item leaves a result behind
    assert property (@(posedge i_clk) disable iff (!i_rst_n) w_accept |=> r_out_valid)
        else $error("accepted item produced no result");

    // A zero bit period leaves the transmitter idle after the item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_bit_period == '0) |=> (!o_tx_busy && o_tx_line))
        else $error("transmitter running with zero bit period");

endmodule
